// ===== design/gne_pkg.sv =====
// Package for the gate netlist evaluator.
// Holds store sizes, lane width, operation and pin codes and the FSM state type.
// No dependencies; used by gne_ram users and gate_netlist_evaluator.
`default_nettype none

package gne_pkg;

  localparam int GATE_REFS = 4096;
  localparam int LANE_BITS = 11;
  localparam int IDX_W     = $clog2(GATE_REFS);
  localparam int REF_W     = 12;
  localparam int VAL_W     = 11;

  localparam logic [LANE_BITS-1:0] LANE_ONES = '1;

  typedef logic [LANE_BITS-1:0] lane_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef enum logic [1:0] {
    OP_INIT_ZERO = 2'd0,
    OP_LOAD      = 2'd1,
    OP_XOR       = 2'd2,
    OP_AND       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PIN_FIRST  = 2'd0,
    PIN_SECOND = 2'd1,
    PIN_OUTPUT = 2'd2
  } pin_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic busy;
    logic we_first;
    logic we_second;
    logic we_output;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== design/gne_ram.sv =====
// Generic synchronous RAM: one write port, two read ports with registered data.
// Width and depth set by parameters; no package dependency.
`default_nettype none

module gne_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ===== design/gate_netlist_evaluator.sv =====
// Gate netlist evaluator top level: first pin, second pin and output stores.
// Depends on gne_pkg and gne_ram.
// done and gate_value are registered in the write-back state that follows an accepted request.
// busy blocks a new request while the write-back of the registered store read is under way.
// Reset clears control state and zero_gate_ref; the stores are not cleared.
// The receiver cannot stall: each result is shown on done for one cycle.
`default_nettype none

module gate_netlist_evaluator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op,
  input  wire logic [11:0] src_a_ref,
  input  wire logic [1:0]  src_a_pin,
  input  wire logic [11:0] src_b_ref,
  input  wire logic [1:0]  src_b_pin,
  input  wire logic [11:0] target_ref,
  input  wire logic [10:0] load_value,
  output logic             done,
  output logic [10:0]      gate_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [11:0] cfg_data
);

  gne_pkg::state_t state, state_next;
  gne_pkg::ctrl_t  ctrl;

  logic                  accept;
  logic [gne_pkg::REF_W-1:0] zero_gate_ref;

  gne_pkg::op_t  cur_op;
  gne_pkg::pin_t cur_a_pin;
  gne_pkg::pin_t cur_b_pin;
  logic          cur_fwd;
  gne_pkg::idx_t cur_target;
  gne_pkg::lane_t cur_load;

  gne_pkg::idx_t  ra_idx, rb_idx, w_idx;
  gne_pkg::lane_t first_a, first_b, second_a, second_b, out_a, out_b;
  gne_pkg::lane_t a_val, b_val, first_wd, second_wd, out_wd;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign ra_idx    = src_a_ref[gne_pkg::IDX_W-1:0];
  assign rb_idx    = src_b_ref[gne_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_gate_ref <= '0;
    end else if (cfg_valid && cfg_ready) begin
      zero_gate_ref <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gne_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gne_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = gne_pkg::ST_EXEC;
        end
      end
      gne_pkg::ST_EXEC: state_next = gne_pkg::ST_IDLE;
      default:          state_next = gne_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state)
      gne_pkg::ST_EXEC: begin
        ctrl.busy      = 1'b1;
        ctrl.we_first  = 1'b1;
        ctrl.we_second = (cur_op != gne_pkg::OP_LOAD);
        ctrl.we_output = (cur_op != gne_pkg::OP_LOAD);
      end
      default: ctrl = '0;
    endcase
  end

  assign busy = ctrl.busy;

  // latch the request; a second operand naming the target's first pin takes operand a
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op     <= gne_pkg::op_t'(op);
      cur_a_pin  <= gne_pkg::pin_t'(src_a_pin);
      cur_b_pin  <= gne_pkg::pin_t'(src_b_pin);
      cur_fwd    <= (src_b_pin == gne_pkg::PIN_FIRST) &&
                    (rb_idx == target_ref[gne_pkg::IDX_W-1:0]);
      cur_target <= target_ref[gne_pkg::IDX_W-1:0];
      cur_load   <= gne_pkg::LANE_BITS'(load_value);
    end
  end

  gne_ram #(.WIDTH(gne_pkg::LANE_BITS), .DEPTH(gne_pkg::GATE_REFS)) u_first (
    .clk(clk), .we(ctrl.we_first), .waddr(w_idx), .wdata(first_wd),
    .re(accept), .raddr_a(ra_idx), .raddr_b(rb_idx),
    .rdata_a(first_a), .rdata_b(first_b)
  );

  gne_ram #(.WIDTH(gne_pkg::LANE_BITS), .DEPTH(gne_pkg::GATE_REFS)) u_second (
    .clk(clk), .we(ctrl.we_second), .waddr(w_idx), .wdata(second_wd),
    .re(accept), .raddr_a(ra_idx), .raddr_b(rb_idx),
    .rdata_a(second_a), .rdata_b(second_b)
  );

  gne_ram #(.WIDTH(gne_pkg::LANE_BITS), .DEPTH(gne_pkg::GATE_REFS)) u_output (
    .clk(clk), .we(ctrl.we_output), .waddr(w_idx), .wdata(out_wd),
    .re(accept), .raddr_a(ra_idx), .raddr_b(rb_idx),
    .rdata_a(out_a), .rdata_b(out_b)
  );

  always_comb begin
    case (cur_a_pin)
      gne_pkg::PIN_FIRST:  a_val = first_a;
      gne_pkg::PIN_SECOND: a_val = second_a;
      default:             a_val = out_a;
    endcase
    if (cur_fwd) begin
      b_val = a_val;
    end else begin
      case (cur_b_pin)
        gne_pkg::PIN_FIRST:  b_val = first_b;
        gne_pkg::PIN_SECOND: b_val = second_b;
        default:             b_val = out_b;
      endcase
    end
  end

  always_comb begin
    w_idx     = cur_target;
    first_wd  = a_val;
    second_wd = b_val;
    out_wd    = a_val & b_val;
    case (cur_op)
      gne_pkg::OP_INIT_ZERO: begin
        w_idx     = zero_gate_ref[gne_pkg::IDX_W-1:0];
        first_wd  = '0;
        second_wd = gne_pkg::LANE_ONES;
        out_wd    = gne_pkg::LANE_ONES;
      end
      gne_pkg::OP_LOAD: begin
        first_wd = cur_load;
        out_wd   = cur_load;
      end
      gne_pkg::OP_XOR: out_wd = a_val ^ b_val;
      gne_pkg::OP_AND: out_wd = a_val & b_val;
      default:         out_wd = a_val & b_val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.busy;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.busy) begin
      gate_value <= gne_pkg::VAL_W'(out_wd);
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("accepted request did not enter write-back");
  a_exec_single: assert property (@(posedge clk) disable iff (rst) busy |=> !busy)
    else $error("write-back lasted more than one cycle");
  a_exec_done: assert property (@(posedge clk) disable iff (rst) busy |=> done)
    else $error("write-back gave no result strobe");
  a_done_origin: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without write-back");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for gate_netlist_evaluator: directed gate programmes, then random ones.
// Predicts each gate_value from its own copy of the three pin stores and the constant gate ref.
// Depends on gne_pkg and the RTL of gate_netlist_evaluator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          PHASE_ITEMS = 100;
  localparam logic [1:0]  PIN_OUTPUT_ALT = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  op;
  logic [11:0] src_a_ref;
  logic [1:0]  src_a_pin;
  logic [11:0] src_b_ref;
  logic [1:0]  src_b_pin;
  logic [11:0] target_ref;
  logic [10:0] load_value;
  logic        done;
  logic [10:0] gate_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [11:0] cfg_data;

  gne_pkg::lane_t first_pin_mem  [gne_pkg::GATE_REFS];
  gne_pkg::lane_t second_pin_mem [gne_pkg::GATE_REFS];
  gne_pkg::lane_t output_mem     [gne_pkg::GATE_REFS];
  bit    first_written  [gne_pkg::GATE_REFS];
  bit    second_written [gne_pkg::GATE_REFS];
  bit    output_written [gne_pkg::GATE_REFS];
  gne_pkg::idx_t  first_refs[$];
  gne_pkg::idx_t  second_refs[$];
  gne_pkg::idx_t  output_refs[$];
  gne_pkg::idx_t  zero_ref;

  gne_pkg::lane_t expected_gate_values[$];
  gne_pkg::lane_t expected_value;
  int    errors;
  int    cycle_count;

  gate_netlist_evaluator DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .src_a_ref (src_a_ref),
    .src_a_pin (src_a_pin),
    .src_b_ref (src_b_ref),
    .src_b_pin (src_b_pin),
    .target_ref(target_ref),
    .load_value(load_value),
    .done      (done),
    .gate_value(gate_value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void note_written(logic [1:0] store, gne_pkg::idx_t r);
    case (store)
      gne_pkg::PIN_FIRST: begin
        if (!first_written[r]) begin
          first_written[r] = 1'b1;
          first_refs.insert(first_refs.size(), r);
        end
      end
      gne_pkg::PIN_SECOND: begin
        if (!second_written[r]) begin
          second_written[r] = 1'b1;
          second_refs.insert(second_refs.size(), r);
        end
      end
      default: begin
        if (!output_written[r]) begin
          output_written[r] = 1'b1;
          output_refs.insert(output_refs.size(), r);
        end
      end
    endcase
  endfunction

  function automatic gne_pkg::lane_t read_store(logic [1:0] pin, gne_pkg::idx_t r);
    gne_pkg::lane_t v;
    case (pin)
      gne_pkg::PIN_FIRST:  v = first_pin_mem[r];
      gne_pkg::PIN_SECOND: v = second_pin_mem[r];
      default:             v = output_mem[r];
    endcase
    return v;
  endfunction

  function automatic gne_pkg::lane_t predict_gate_value(logic [1:0] o, logic [11:0] ar,
                                                        logic [1:0] ap, logic [11:0] br,
                                                        logic [1:0] bp, logic [11:0] tr,
                                                        gne_pkg::lane_t lv);
    gne_pkg::idx_t  t;
    gne_pkg::idx_t  z;
    gne_pkg::lane_t v;
    t = tr;
    z = zero_ref;
    case (o)
      gne_pkg::OP_INIT_ZERO: begin
        first_pin_mem[z]  = '0;
        second_pin_mem[z] = gne_pkg::LANE_ONES;
        output_mem[z]     = first_pin_mem[z] ^ second_pin_mem[z];
        note_written(gne_pkg::PIN_FIRST, z);
        note_written(gne_pkg::PIN_SECOND, z);
        note_written(gne_pkg::PIN_OUTPUT, z);
        v = output_mem[z];
      end
      gne_pkg::OP_LOAD: begin
        first_pin_mem[t] = lv;
        note_written(gne_pkg::PIN_FIRST, t);
        v = lv;
      end
      default: begin
        first_pin_mem[t] = read_store(ap, ar);
        note_written(gne_pkg::PIN_FIRST, t);
        second_pin_mem[t] = read_store(bp, br);
        note_written(gne_pkg::PIN_SECOND, t);
        if (o == gne_pkg::OP_XOR) output_mem[t] = first_pin_mem[t] ^ second_pin_mem[t];
        else output_mem[t] = first_pin_mem[t] & second_pin_mem[t];
        note_written(gne_pkg::PIN_OUTPUT, t);
        v = output_mem[t];
      end
    endcase
    return v;
  endfunction

  function automatic gne_pkg::idx_t pick_written_ref(logic [1:0] pin);
    int n;
    int k;
    case (pin)
      gne_pkg::PIN_FIRST:  n = first_refs.size();
      gne_pkg::PIN_SECOND: n = second_refs.size();
      default:             n = output_refs.size();
    endcase
    if (n > 4 && $urandom_range(0, 1) == 1) k = n - 1 - int'($urandom_range(0, 3));
    else k = int'($urandom_range(0, n - 1));
    case (pin)
      gne_pkg::PIN_FIRST:  return first_refs[k];
      gne_pkg::PIN_SECOND: return second_refs[k];
      default:             return output_refs[k];
    endcase
  endfunction

  task automatic send_request(logic [1:0] o, logic [11:0] ar, logic [1:0] ap,
                              logic [11:0] br, logic [1:0] bp,
                              logic [11:0] tr, logic [10:0] lv);
    @(negedge clk);
    start      <= 1'b1;
    op         <= o;
    src_a_ref  <= ar;
    src_a_pin  <= ap;
    src_b_ref  <= br;
    src_b_pin  <= bp;
    target_ref <= tr;
    load_value <= lv;
    do @(posedge clk); while (busy);
    expected_gate_values.insert(expected_gate_values.size(),
                                predict_gate_value(o, ar, ap, br, bp, tr, lv));
  endtask

  task automatic pause_requests(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain_results;
    @(negedge clk);
    start <= 1'b0;
    while (expected_gate_values.size() != 0) @(negedge clk);
  endtask

  task automatic write_zero_gate_ref(logic [11:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    zero_ref = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_constant_gate;
    write_zero_gate_ref(12'h000);
    send_request(gne_pkg::OP_INIT_ZERO, 12'hFFF, PIN_OUTPUT_ALT, 12'hFFF, PIN_OUTPUT_ALT,
                 12'hFFF, 11'h7FF);
    write_zero_gate_ref(12'hFFF);
    send_request(gne_pkg::OP_INIT_ZERO, 12'h000, gne_pkg::PIN_FIRST, 12'h000,
                 gne_pkg::PIN_FIRST, 12'h000, 11'h000);
  endtask

  task automatic test_load_words;
    send_request(gne_pkg::OP_LOAD, 12'hFFF, PIN_OUTPUT_ALT, 12'hFFF, PIN_OUTPUT_ALT,
                 12'h000, 11'h000);
    send_request(gne_pkg::OP_LOAD, 12'h000, gne_pkg::PIN_FIRST, 12'h000, gne_pkg::PIN_FIRST,
                 12'hFFF, 11'h7FF);
    send_request(gne_pkg::OP_LOAD, 12'h555, gne_pkg::PIN_SECOND, 12'hAAA, gne_pkg::PIN_OUTPUT,
                 12'hAAA, 11'h2AA);
    send_request(gne_pkg::OP_LOAD, 12'hAAA, gne_pkg::PIN_OUTPUT, 12'h555, gne_pkg::PIN_SECOND,
                 12'h555, 11'h555);
    send_request(gne_pkg::OP_LOAD, 12'($urandom_range(0, 4095)), 2'($urandom_range(0, 3)),
                 12'($urandom_range(0, 4095)), 2'($urandom_range(0, 3)), 12'h123,
                 11'($urandom_range(0, 2047)));
  endtask

  task automatic test_gate_ops;
    send_request(gne_pkg::OP_XOR, 12'hAAA, gne_pkg::PIN_FIRST, 12'h555, gne_pkg::PIN_FIRST,
                 12'h010, 11'h7FF);
    send_request(gne_pkg::OP_AND, 12'hAAA, gne_pkg::PIN_FIRST, 12'h555, gne_pkg::PIN_FIRST,
                 12'h011, 11'h000);
    send_request(gne_pkg::OP_AND, 12'h555, gne_pkg::PIN_FIRST, 12'h000, gne_pkg::PIN_SECOND,
                 12'h012, 11'h555);
    send_request(gne_pkg::OP_XOR, 12'h010, gne_pkg::PIN_OUTPUT, 12'h011, gne_pkg::PIN_OUTPUT,
                 12'h013, 11'h2AA);
  endtask

  task automatic test_pin_codes;
    send_request(gne_pkg::OP_XOR, 12'h000, PIN_OUTPUT_ALT, 12'hAAA, gne_pkg::PIN_FIRST,
                 12'h020, 11'h000);
    send_request(gne_pkg::OP_AND, 12'h012, gne_pkg::PIN_SECOND, 12'hFFF, PIN_OUTPUT_ALT,
                 12'h021, 11'h7FF);
  endtask

  task automatic test_operand_order;
    send_request(gne_pkg::OP_AND, 12'h555, gne_pkg::PIN_FIRST, 12'h030, gne_pkg::PIN_FIRST,
                 12'h030, 11'h000);
    send_request(gne_pkg::OP_XOR, 12'hAAA, gne_pkg::PIN_FIRST, 12'h031, gne_pkg::PIN_FIRST,
                 12'h031, 11'h7FF);
  endtask

  task automatic test_self_reference;
    send_request(gne_pkg::OP_XOR, 12'h013, gne_pkg::PIN_OUTPUT, 12'h013, gne_pkg::PIN_SECOND,
                 12'h013, 11'h001);
    send_request(gne_pkg::OP_AND, 12'h123, gne_pkg::PIN_FIRST, 12'h010, gne_pkg::PIN_OUTPUT,
                 12'h123, 11'h400);
  endtask

  task automatic test_random_programme(int items, logic [11:0] zref);
    int          burst;
    int          sent;
    logic [1:0]  o;
    logic [1:0]  ap;
    logic [1:0]  bp;
    logic [11:0] ar;
    logic [11:0] br;
    logic [11:0] tr;
    write_zero_gate_ref(zref);
    burst = int'($urandom_range(1, 12));
    for (sent = 0; sent < items; sent++) begin
      if (burst == 0) begin
        pause_requests(int'($urandom_range(1, 6)));
        burst = ($urandom_range(0, 4) == 0) ? int'($urandom_range(20, 40)) :
                                              int'($urandom_range(1, 12));
      end
      burst--;
      case ($urandom_range(0, 9))
        0:       o = gne_pkg::OP_INIT_ZERO;
        1, 2:    o = gne_pkg::OP_LOAD;
        3, 4, 5: o = gne_pkg::OP_XOR;
        default: o = gne_pkg::OP_AND;
      endcase
      case ($urandom_range(0, 9))
        0, 1:    tr = pick_written_ref(gne_pkg::PIN_FIRST);
        2:       tr = pick_written_ref(gne_pkg::PIN_OUTPUT);
        3, 4:    tr = 12'($urandom_range(0, 15));
        5:       tr = zero_ref;
        default: tr = 12'($urandom_range(0, 4095));
      endcase
      ap = 2'($urandom_range(0, 3));
      bp = 2'($urandom_range(0, 3));
      if (o == gne_pkg::OP_INIT_ZERO || o == gne_pkg::OP_LOAD) begin
        ar = 12'($urandom_range(0, 4095));
        br = 12'($urandom_range(0, 4095));
      end else begin
        ar = pick_written_ref(ap);
        if ($urandom_range(0, 7) == 0) begin
          bp = gne_pkg::PIN_FIRST;
          br = tr;
        end else begin
          br = pick_written_ref(bp);
        end
      end
      send_request(o, ar, ap, br, bp, tr, 11'($urandom_range(0, 2047)));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_gate_values.size() == 0) begin
        $error("gate_value: expected none, actual %h", gate_value);
        errors++;
      end else begin
        expected_value = expected_gate_values.pop_front();
        if (gate_value !== expected_value) begin
          $error("gate_value: expected %h, actual %h", expected_value, gate_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    errors      = 0;
    cycle_count = 0;
    zero_ref    = '0;
    rst         = 1'b1;
    start       = 1'b0;
    op          = gne_pkg::OP_INIT_ZERO;
    src_a_ref   = '0;
    src_a_pin   = gne_pkg::PIN_FIRST;
    src_b_ref   = '0;
    src_b_pin   = gne_pkg::PIN_FIRST;
    target_ref  = '0;
    load_value  = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_constant_gate();
    test_load_words();
    test_gate_ops();
    test_pin_codes();
    test_operand_order();
    test_self_reference();
    test_random_programme(PHASE_ITEMS, 12'($urandom_range(0, 4095)));
    test_random_programme(PHASE_ITEMS, 12'hFFF);
    test_random_programme(PHASE_ITEMS, 12'($urandom_range(0, 4095)));
    test_random_programme(PHASE_ITEMS, 12'h000);

    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
design/gne_pkg.sv
design/gne_ram.sv
design/gate_netlist_evaluator.sv
dv/tb.sv
